@@ hw/rtl/cdq_pkg.sv @@
// ---------------------------------------------------------------------------
// cdq_pkg - circular deque shared definitions
// Opcode and status codes, field widths.
// ---------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned STAT_W = 2;

    typedef logic [OP_W-1:0]   t_opcode;
    typedef logic [STAT_W-1:0] t_status;
    typedef logic [WORD_W-1:0] t_word;

    localparam t_opcode OP_PUSH_FRONT = 3'd0;
    localparam t_opcode OP_PUSH_BACK  = 3'd1;
    localparam t_opcode OP_POP_FRONT  = 3'd2;
    localparam t_opcode OP_POP_BACK   = 3'd3;
    localparam t_opcode OP_PEEK_FRONT = 3'd4;
    localparam t_opcode OP_PEEK_BACK  = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/circular_deque.sv @@
// ---------------------------------------------------------------------------
// circular_deque - double-ended queue on a circular word store
// Push/pop/peek at either end; one result transfer per command transfer.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)      | tuser (low bit up)
//  s       | in  | value[31:0]             | opcode[2:0]
//  m       | out | word[31:0]              | status[1:0]
//
//  Cycles: one command per cycle sustained while results are taken.
//  The single-port store is written or read at the edge that takes
//  the command; read data lands in stage 1 at that same edge, then
//  moves on to the output register, where a stall can hold it.
//  Reset: clears indices, fill count and valid flags; the store is not
//  cleared (entries are only read after being written).
//  Stalls: a skid of stage 1 plus output register; the input stalls only
//  when both hold results that are not taken.
// ---------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // value[31:0]
    input  wire logic [2:0]  i_s_tuser,   // opcode[2:0]
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // word[31:0]
    output logic [1:0]       o_m_tuser    // status[1:0]
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    // word store
    cdq_pkg::t_word r_mem [DEPTH];
    cdq_pkg::t_word r_rd_data;

    // queue state
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    // stage 1: command done, read data pending
    logic                r_s1_vld;
    logic                r_s1_rd;
    cdq_pkg::t_status    r_s1_status;

    // output register
    logic                r_o_vld;
    cdq_pkg::t_word      r_o_word;
    cdq_pkg::t_status    r_o_status;

    cdq_pkg::t_opcode    op;
    cdq_pkg::t_status    cmd_status;
    logic                in_fire, s1_move;
    logic                is_push, is_rd, is_pop, at_front;
    logic                q_empty, q_full;
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [AW-1:0]       head_prev, head_next, tail_prev, tail_next;

    // ---- handshakes ----
    assign s1_move    = !r_o_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || s1_move;
    assign in_fire    = i_s_tvalid && o_s_tready;

    // ---- command decode ----
    assign op       = i_s_tuser;
    assign is_push  = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_PUSH_BACK);
    assign is_rd    = (op == cdq_pkg::OP_POP_FRONT)  || (op == cdq_pkg::OP_POP_BACK)
                   || (op == cdq_pkg::OP_PEEK_FRONT) || (op == cdq_pkg::OP_PEEK_BACK);
    assign is_pop   = (op == cdq_pkg::OP_POP_FRONT)  || (op == cdq_pkg::OP_POP_BACK);
    assign at_front = (op == cdq_pkg::OP_PUSH_FRONT) || (op == cdq_pkg::OP_POP_FRONT)
                   || (op == cdq_pkg::OP_PEEK_FRONT);
    assign q_empty  = (r_count == '0);
    assign q_full   = (r_count == CNT_FULL);

    // index wrap, both directions (DEPTH need not be a power of two)
    assign head_prev = (r_head == '0)       ? IDX_LAST : r_head - AW'(1);
    assign head_next = (r_head == IDX_LAST) ? '0       : r_head + AW'(1);
    assign tail_prev = (r_tail == '0)       ? IDX_LAST : r_tail - AW'(1);
    assign tail_next = (r_tail == IDX_LAST) ? '0       : r_tail + AW'(1);

    always_comb begin
        cmd_status = cdq_pkg::ST_OK;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = '0;
        rd_addr    = at_front ? r_head : r_tail;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        if (is_push) begin
            if (q_full) begin
                cmd_status = cdq_pkg::ST_FULL;
            end else begin
                wr_en   = in_fire;
                n_count = r_count + CW'(1);
                if (q_empty) begin
                    // first word always lands in entry zero
                    n_head  = '0;
                    n_tail  = '0;
                    wr_addr = '0;
                end else if (at_front) begin
                    n_head  = head_prev;
                    wr_addr = head_prev;
                end else begin
                    n_tail  = tail_next;
                    wr_addr = tail_next;
                end
            end
        end else if (is_rd) begin
            if (q_empty) begin
                cmd_status = cdq_pkg::ST_EMPTY;
            end else begin
                rd_en = in_fire;
                if (is_pop) begin
                    n_count = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        n_head = '0;
                        n_tail = '0;
                    end else if (at_front) begin
                        n_head = head_next;
                    end else begin
                        n_tail = tail_prev;
                    end
                end
            end
        end
    end

    // ---- store: one access per command ----
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_s_tdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // ---- queue state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (in_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_rd  <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= in_fire;
            r_s1_rd  <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_status <= cmd_status;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_move) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_vld) begin
            r_o_word   <= r_s1_rd ? r_rd_data : '0;   // zero unless a word was read
            r_o_status <= r_s1_status;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_word;
    assign o_m_tuser  = r_o_status;

    // ---- assertions ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count above depth");

    a_empty_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == '0) && (r_tail == '0))
        else $error("indices not home on empty queue");

    a_rd_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_rd |-> r_s1_vld && (r_s1_status == cdq_pkg::ST_OK))
        else $error("store read flagged on a non-ok result");

    a_push_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not grow fill count");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> r_s1_vld && $stable(r_s1_status))
        else $error("stage 1 result lost under stall");

endmodule

`default_nettype wire

@@ tb/tb_circular_deque.sv @@
// ---------------------------------------------------------------------------
// tb_circular_deque - self-checking bench for the circular deque
// Drives push/pop/peek commands into the slave stream with random idle
// gaps and receiver stalls. A transaction-level copy of the deque predicts
// every result, and each result is compared in order, word and status.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_circular_deque;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = 128;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    localparam int unsigned MAX_CYCLES = 200_000;
    localparam int unsigned REPORT_MAX = 10;
    localparam int unsigned DRAIN_WAIT = 8;     // output latency plus margin
    localparam int unsigned HOLD_OFF   = 80;    // long receiver stall
    localparam int unsigned HOLD_AFTER = 150;   // results seen before it

    // opcodes the block must ignore
    localparam cdq_pkg::t_opcode OP_UNDEF_6 = 3'd6;
    localparam cdq_pkg::t_opcode OP_UNDEF_7 = 3'd7;

    typedef struct packed {
        cdq_pkg::t_word   word;
        cdq_pkg::t_status status;
    } t_deque_result;

    // -----------------------------------------------------------------------
    // Deque predictor and result scoreboard
    // -----------------------------------------------------------------------
    class deque_model;
        cdq_pkg::t_word     words [DEPTH];
        logic [IDX_W-1:0]   head;
        logic [IDX_W-1:0]   tail;
        int unsigned        fill;
        t_deque_result      expected_results [$];
        int unsigned        mismatches;

        function new();
            head       = '0;
            tail       = '0;
            fill       = 0;
            mismatches = 0;
        endfunction

        // apply one accepted command and queue the result it must produce
        function void take_command(cdq_pkg::t_opcode op, cdq_pkg::t_word value);
            t_deque_result res;
            bit            front;
            res.word   = '0;
            res.status = cdq_pkg::ST_OK;
            front      = (op == cdq_pkg::OP_PUSH_FRONT || op == cdq_pkg::OP_POP_FRONT ||
                          op == cdq_pkg::OP_PEEK_FRONT);
            case (op)
                cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
                    if (fill == DEPTH) begin
                        res.status = cdq_pkg::ST_FULL;
                    end else begin
                        // first word of an empty deque always lands at slot 0
                        if (fill == 0) begin
                            head = '0;
                            tail = '0;
                        end else if (front) begin
                            head = head - 1'b1;
                        end else begin
                            tail = tail + 1'b1;
                        end
                        words[front ? head : tail] = value;
                        fill++;
                    end
                end
                cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK,
                cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_BACK: begin
                    if (fill == 0) begin
                        res.status = cdq_pkg::ST_EMPTY;
                    end else begin
                        res.word = words[front ? head : tail];
                        if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_POP_BACK) begin
                            fill--;
                            if (fill == 0) begin
                                head = '0;
                                tail = '0;
                            end else if (front) begin
                                head = head + 1'b1;
                            end else begin
                                tail = tail - 1'b1;
                            end
                        end
                    end
                end
                default: ;  // undefined opcode: no state change, status ok
            endcase
            expected_results.push_back(res);
        endfunction

        function void report(string what, t_deque_result exp, cdq_pkg::t_word word,
                             cdq_pkg::t_status status);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s: expected word %h status %0d, got word %h status %0d",
                         $realtime, what, exp.word, exp.status, word, status);
        endfunction

        function void check_result(cdq_pkg::t_word word, cdq_pkg::t_status status);
            t_deque_result exp;
            if (expected_results.size() == 0) begin
                exp = '0;
                report("unexpected result", exp, word, status);
                return;
            end
            exp = expected_results.pop_front();
            if (word !== exp.word || status !== exp.status)
                report("result differs", exp, word, status);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, DUT signals and instance
    // -----------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;     // value[31:0]
    logic [2:0]  i_s_tuser;     // opcode[2:0]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;     // word[31:0]
    logic [1:0]  o_m_tuser;     // status[1:0]

    deque_model  model = new();
    int unsigned results_taken;
    int unsigned no_gap_left;
    int unsigned cycles;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circular_deque #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // -----------------------------------------------------------------------
    // Transfer monitor: commands go into the predictor, results are checked.
    // Commands are noted first, although the latency keeps a result from
    // ever sharing an edge with its own command.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                model.take_command(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                model.check_result(o_m_tdata, o_m_tuser);
                results_taken++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // word to push: extremes now and then, otherwise fully random
    function automatic cdq_pkg::t_word pick_value();
        case ($urandom_range(0, 39))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Command driver: optional idle gap, then hold the transfer until taken.
    // tvalid stays high across back-to-back transfers (no drop and re-raise
    // within one step).
    // -----------------------------------------------------------------------
    task automatic send_cmd(cdq_pkg::t_opcode op, cdq_pkg::t_word value);
        int unsigned gap;
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else begin
            gap = idle_cycles();
            if ($urandom_range(0, 49) == 0)
                no_gap_left = $urandom_range(20, 40);   // gap-free burst
        end
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // random phase; push_pct sets the drift toward full or toward empty
    task automatic run_phase(int unsigned n_items, int unsigned push_pct);
        int unsigned      r;
        cdq_pkg::t_opcode op;
        repeat (n_items) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                op = ($urandom_range(0, 1) != 0) ? OP_UNDEF_7 : OP_UNDEF_6;
            else if (r < 2 + push_pct)
                op = ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_PUSH_BACK
                                                 : cdq_pkg::OP_PUSH_FRONT;
            else if ($urandom_range(0, 3) != 0)
                op = ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_POP_BACK
                                                 : cdq_pkg::OP_POP_FRONT;
            else
                op = ($urandom_range(0, 1) != 0) ? cdq_pkg::OP_PEEK_BACK
                                                 : cdq_pkg::OP_PEEK_FRONT;
            // value is ignored outside pushes, still drive random bits
            send_cmd(op, pick_value());
        end
    endtask

    // -----------------------------------------------------------------------
    // Result receiver: random ready runs and stalls, plus one long hold-off
    // so the skid stages fill and the command side backs up.
    // -----------------------------------------------------------------------
    initial begin
        bit          held;
        int unsigned stall;
        held = 1'b0;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!held && results_taken >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(30, 60)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            stall = idle_cycles();
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        results_taken = 0;
        no_gap_left   = 0;
        cycles        = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= cdq_pkg::OP_PUSH_FRONT;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty reads, ignored opcodes, front wrap, last-word pop
        send_cmd(cdq_pkg::OP_POP_FRONT,  $urandom);
        send_cmd(cdq_pkg::OP_POP_BACK,   $urandom);
        send_cmd(cdq_pkg::OP_PEEK_FRONT, $urandom);
        send_cmd(cdq_pkg::OP_PEEK_BACK,  $urandom);
        send_cmd(OP_UNDEF_6,             32'hffff_ffff);
        send_cmd(OP_UNDEF_7,             32'h0000_0000);
        send_cmd(cdq_pkg::OP_PUSH_FRONT, 32'h7fff_ffff);    // into empty: slot 0
        send_cmd(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);    // head wraps below 0
        send_cmd(cdq_pkg::OP_PUSH_BACK,  32'hffff_ffff);
        send_cmd(cdq_pkg::OP_PUSH_BACK,  32'h0000_0000);
        send_cmd(cdq_pkg::OP_PEEK_FRONT, $urandom);
        send_cmd(cdq_pkg::OP_PEEK_BACK,  $urandom);
        send_cmd(cdq_pkg::OP_POP_FRONT,  $urandom);         // head wraps back to 0
        send_cmd(cdq_pkg::OP_POP_BACK,   $urandom);
        send_cmd(cdq_pkg::OP_POP_FRONT,  $urandom);
        send_cmd(cdq_pkg::OP_POP_BACK,   $urandom);         // last word: indices reset
        send_cmd(cdq_pkg::OP_POP_BACK,   $urandom);
        send_cmd(cdq_pkg::OP_PUSH_BACK,  32'h1234_5678);    // back push into empty
        send_cmd(OP_UNDEF_7,             $urandom);         // ignored while not empty
        send_cmd(cdq_pkg::OP_PEEK_BACK,  $urandom);
        send_cmd(cdq_pkg::OP_POP_FRONT,  $urandom);

        // random: fill to full and beyond, churn, drain, drain to empty
        run_phase(180, 90);
        run_phase(120, 40);
        run_phase(180, 8);
        run_phase(120, 25);
        i_s_tvalid <= 1'b0;

        // one more edge so the monitor has noted the last command
        @(posedge i_clk);
        while (model.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (model.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
